[src/soit_pkg.sv]
// ============================================================================
// soit_pkg
// Types, sizes and codes shared by the sparse offset index table.
// ============================================================================
package soit_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int OFF_W       = 64;
    localparam int REL_W       = 32;
    localparam int POS_W       = 32;
    localparam int ENTRY_W     = REL_W + POS_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_ENTRIES);

    typedef enum logic [0:0] {
        REQ_APPEND = 1'b0,
        REQ_LOOKUP = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ORDER = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TAIL_PRE,
        S_APPEND,
        S_SUB,
        S_FIRST,
        S_SEARCH,
        S_HIT,
        S_TAIL,
        S_DONE
    } soit_state_t;

    typedef struct packed {
        req_kind_t          req_type;
        logic [OFF_W-1:0]   abs_offset;
        logic [POS_W-1:0]   phys_position;
    } soit_req_t;

    typedef struct packed {
        status_t            status;
        logic [OFF_W-1:0]   hit_offset;
        logic [POS_W-1:0]   hit_position;
        logic [COUNT_W-1:0] count_now;
        logic [OFF_W-1:0]   tail_offset;
        logic [POS_W-1:0]   tail_position;
    } soit_rsp_t;

endpackage

[src/sparse_offset_index_table_unit.sv]
// Append steps: tail add, check/write, tail add, output.
// Lookup: k search steps, k at most ceil(log2(entries)) (10 for a full table),
// one step per cycle, set by the single RAM read port feeding the shared compare.
// Next item taken in the cycle after the result is loaded.
// One item at a time; a finished result waits in the output register while the next is taken.
// Reset (rst_n, async, active low) empties the table and clears the base register.
// ============================================================================
// sparse_offset_index_table_unit
// Sorted offset/position table with append and floor lookup by binary search.
// ============================================================================
module sparse_offset_index_table_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  soit_pkg::soit_req_t           req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output soit_pkg::soit_rsp_t           rsp,
    input  logic                          cfg_wr_en,
    input  logic [soit_pkg::OFF_W-1:0]    cfg_wr_data
);

    import soit_pkg::*;

    soit_state_t        state_reg, state_next;
    logic [OFF_W-1:0]   base_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [REL_W-1:0]   tail_rel_reg, tail_rel_next;
    logic [POS_W-1:0]   tail_pos_reg, tail_pos_next;
    soit_req_t          item_reg, item_next;
    logic [OFF_W-1:0]   acc_reg, acc_next;
    logic [REL_W-1:0]   rel_lo_reg, rel_lo_next;
    logic               rel_hi_nz_reg, rel_hi_nz_next;
    logic               below_reg, below_next;
    logic [IDX_W-1:0]   lo_reg, lo_next;
    logic [IDX_W-1:0]   hi_reg, hi_next;
    logic [IDX_W-1:0]   mid_reg, mid_next;
    logic [ENTRY_W-1:0] lo_data_reg, lo_data_next;
    logic [ENTRY_W-1:0] sel_reg, sel_next;
    status_t            status_reg, status_next;
    logic [OFF_W-1:0]   hit_off_reg, hit_off_next;
    logic [POS_W-1:0]   hit_pos_reg, hit_pos_next;
    soit_rsp_t          rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic [OFF_W-1:0]   add_a, add_b;
    logic               add_sub;
    logic [OFF_W:0]     add_sum;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_addr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    logic [REL_W-1:0]   ent_rel;
    logic               ent_eq, ent_lt, ent_gt;
    logic [COUNT_W-1:0] count_m1;
    logic               first_none;
    logic [IDX_W-1:0]   step_lo, step_hi, step_mid;
    logic [IDX_W:0]     mid_sum;
    logic               step_more;
    logic               append_full, append_order;
    logic               req_accept, out_free;

    // shared 64-bit adder/subtractor
    assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {OFF_W{add_sub}}} + {{OFF_W{1'b0}}, add_sub};

    soit_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    assign ent_rel = ram_rdata[ENTRY_W-1 -: REL_W];
    assign ent_eq  = !rel_hi_nz_reg && (ent_rel == rel_lo_reg);
    assign ent_lt  = rel_hi_nz_reg || (ent_rel < rel_lo_reg);
    assign ent_gt  = !rel_hi_nz_reg && (ent_rel > rel_lo_reg);

    assign count_m1     = count_reg - COUNT_W'(1);
    assign first_none   = (count_reg == '0) || below_reg || ent_gt;
    assign append_full  = (count_reg == COUNT_MAX);
    assign append_order = (count_reg != '0) && (item_reg.abs_offset <= acc_reg);

    // next search bounds
    always_comb
    begin
        if (state_reg == S_FIRST)
        begin
            step_lo = '0;
            step_hi = count_m1[IDX_W-1:0];
        end
        else if (ent_lt)
        begin
            step_lo = mid_reg;
            step_hi = hi_reg;
        end
        else
        begin
            step_lo = lo_reg;
            step_hi = mid_reg - IDX_W'(1);
        end
    end

    assign mid_sum   = {1'b0, step_lo} + {1'b0, step_hi} + (IDX_W+1)'(1);
    assign step_mid  = mid_sum[IDX_W:1];
    assign step_more = (step_lo < step_hi);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = (req.req_type == REQ_APPEND) ? S_TAIL_PRE : S_SUB;
                end
            end
            S_TAIL_PRE: state_next = S_APPEND;
            S_APPEND:   state_next = S_TAIL;
            S_SUB:      state_next = S_FIRST;
            S_FIRST:
            begin
                if (first_none)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    state_next = step_more ? S_SEARCH : S_HIT;
                end
            end
            S_SEARCH:
            begin
                if (ent_eq || !step_more)
                begin
                    state_next = S_HIT;
                end
            end
            S_HIT:  state_next = S_TAIL;
            S_TAIL: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        tail_rel_next  = tail_rel_reg;
        tail_pos_next  = tail_pos_reg;
        item_next      = item_reg;
        acc_next       = acc_reg;
        rel_lo_next    = rel_lo_reg;
        rel_hi_nz_next = rel_hi_nz_reg;
        below_next     = below_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        lo_data_next   = lo_data_reg;
        sel_next       = sel_reg;
        status_next    = status_reg;
        hit_off_next   = hit_off_reg;
        hit_pos_next   = hit_pos_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = (rsp_valid_reg && rsp_stall);
        add_a          = base_reg;
        add_b          = {{(OFF_W-REL_W){1'b0}}, tail_rel_reg};
        add_sub        = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = step_mid;
        ram_wdata      = {add_sum[REL_W-1:0], item_reg.phys_position};

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    item_next    = req;
                    status_next  = ST_OK;
                    hit_off_next = '0;
                    hit_pos_next = '0;
                end
            end
            S_TAIL_PRE:
            begin
                acc_next = add_sum[OFF_W-1:0];
            end
            S_APPEND:
            begin
                add_a   = item_reg.abs_offset;
                add_b   = base_reg;
                add_sub = 1'b1;
                if (append_full)
                begin
                    status_next = ST_FULL;
                end
                else if (append_order)
                begin
                    status_next = ST_ORDER;
                end
                else
                begin
                    ram_we        = 1'b1;
                    ram_addr      = count_reg[IDX_W-1:0];
                    count_next    = count_reg + COUNT_W'(1);
                    tail_rel_next = add_sum[REL_W-1:0];
                    tail_pos_next = item_reg.phys_position;
                end
            end
            S_SUB:
            begin
                add_a          = item_reg.abs_offset;
                add_b          = base_reg;
                add_sub        = 1'b1;
                rel_lo_next    = add_sum[REL_W-1:0];
                rel_hi_nz_next = |add_sum[OFF_W-1:REL_W];
                below_next     = !add_sum[OFF_W];
                ram_addr       = '0;
            end
            S_FIRST:
            begin
                if (first_none)
                begin
                    hit_off_next = base_reg;
                    hit_pos_next = '0;
                end
                else
                begin
                    lo_next      = step_lo;
                    hi_next      = step_hi;
                    mid_next     = step_mid;
                    lo_data_next = ram_rdata;
                    sel_next     = ram_rdata;
                end
            end
            S_SEARCH:
            begin
                lo_next  = step_lo;
                hi_next  = step_hi;
                mid_next = step_mid;
                if (ent_lt)
                begin
                    lo_data_next = ram_rdata;
                end
                sel_next = (ent_eq || ent_lt) ? ram_rdata : lo_data_reg;
            end
            S_HIT:
            begin
                add_b        = {{(OFF_W-REL_W){1'b0}}, sel_reg[ENTRY_W-1 -: REL_W]};
                hit_off_next = add_sum[OFF_W-1:0];
                hit_pos_next = sel_reg[POS_W-1:0];
            end
            S_TAIL:
            begin
                acc_next = add_sum[OFF_W-1:0];
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_next.status        = status_reg;
                    rsp_next.hit_offset    = hit_off_reg;
                    rsp_next.hit_position  = hit_pos_reg;
                    rsp_next.count_now     = count_reg;
                    rsp_next.tail_offset   = acc_reg;
                    rsp_next.tail_position = tail_pos_reg;
                    rsp_valid_next         = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= '0;
            count_reg     <= '0;
            tail_rel_reg  <= '0;
            tail_pos_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            tail_rel_reg  <= tail_rel_next;
            tail_pos_reg  <= tail_pos_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        acc_reg       <= acc_next;
        rel_lo_reg    <= rel_lo_next;
        rel_hi_nz_reg <= rel_hi_nz_next;
        below_reg     <= below_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        lo_data_reg   <= lo_data_next;
        sel_reg       <= sel_next;
        status_reg    <= status_next;
        hit_off_reg   <= hit_off_next;
        hit_pos_reg   <= hit_pos_next;
        rsp_reg       <= rsp_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("entry count above table size");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (count_reg < COUNT_MAX) && (state_reg == S_APPEND))
        else $error("store write without room");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != count_next) |-> (state_reg == S_APPEND)
            && (count_next == count_reg + COUNT_W'(1)))
        else $error("entry count changed outside an append");

    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (lo_reg < mid_reg) && (mid_reg <= hi_reg))
        else $error("search probe outside bounds");
`endif

endmodule

[src/soit_ram.sv]
// ============================================================================
// soit_ram
// Single-port RAM, one access per cycle (a write also reads the old word), registered read data.
// ============================================================================
module soit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[addr] <= wdata;
        end
        rdata_reg <= ram_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule
